// ===== rtl/plcd_pkg.sv =====
// ----------------------------------------------------------------------------
// plcd_pkg
// Shared types, constants and the CRC-16 byte step for the frame receiver.
// ----------------------------------------------------------------------------
package plcd_pkg;

  localparam int LEN_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 6;
  localparam int FLEN_W  = 7;
  localparam int CRC_W   = 16;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hA5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h5A;
  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;

  localparam logic MODE_BYTE     = 1'b0;
  localparam logic MODE_OVERFLOW = 1'b1;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic start;
    len_t len;
  } replay_cmd_t;

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] v);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {v, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/plcd_intf.sv =====
// ----------------------------------------------------------------------------
// plcd_in_if / plcd_out_if
// Valid/ready channels for received bytes and for replayed payload bytes.
// ----------------------------------------------------------------------------
interface plcd_in_if;
  import plcd_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface plcd_out_if;
  import plcd_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  payload_byte;
  logic [INDEX_W-1:0] byte_index;
  logic [FLEN_W-1:0]  frame_length;
  logic               last_byte;

  modport source (output valid, output payload_byte, output byte_index,
                  output frame_length, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input byte_index,
                input frame_length, input last_byte, output ready);
endinterface

// ===== rtl/plcd_ram.sv =====
// ----------------------------------------------------------------------------
// plcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module plcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/plcd_parse.sv =====
// ----------------------------------------------------------------------------
// plcd_parse
// Preamble hunt, length check, CRC-16 accumulation, payload store writes and replay start.
// ----------------------------------------------------------------------------
module plcd_parse #(
  parameter int MAX_PAYLOAD_BYTES = 64,
  localparam int AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic                  mode,
  input  logic [7:0]            data_byte,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [7:0]            wdata,
  output plcd_pkg::replay_cmd_t cmd
);
  import plcd_pkg::*;

  localparam logic [1:0] PH_HUNT0 = 2'd0;
  localparam logic [1:0] PH_HUNT1 = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  localparam len_t MAX_LEN = LEN_W'(MAX_PAYLOAD_BYTES);

  logic [1:0]       phase, phase_next;
  len_t             byte_count, byte_count_next;
  len_t             payload_len, payload_len_next;
  logic [CRC_W-1:0] running_crc, running_crc_next;
  logic [7:0]       crc_high_byte, crc_high_byte_next;
  len_t             store_idx;

  assign store_idx = byte_count - len_t'(1);
  assign waddr     = store_idx[AW-1:0];
  assign wdata     = data_byte;

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    payload_len_next   = payload_len;
    running_crc_next   = running_crc;
    crc_high_byte_next = crc_high_byte;
    we                 = 1'b0;
    cmd                = '{start: 1'b0, len: payload_len};
    if (take) begin
      if (mode == MODE_OVERFLOW) begin
        phase_next         = PH_HUNT0;
        byte_count_next    = '0;
        payload_len_next   = '0;
        running_crc_next   = CRC_INIT;
        crc_high_byte_next = '0;
      end else begin
        unique case (phase)
          PH_HUNT1: begin
            if (data_byte == SYNC_SECOND) begin
              phase_next         = PH_BODY;
              byte_count_next    = '0;
              payload_len_next   = '0;
              running_crc_next   = CRC_INIT;
              crc_high_byte_next = '0;
            end else if (data_byte != SYNC_FIRST) begin
              phase_next = PH_HUNT0;
            end
          end
          PH_BODY: begin
            priority if (byte_count == '0) begin
              if (data_byte == '0 || data_byte > MAX_LEN) begin
                phase_next         = PH_HUNT0;
                payload_len_next   = '0;
                running_crc_next   = CRC_INIT;
                crc_high_byte_next = '0;
              end else begin
                payload_len_next = data_byte;
                running_crc_next = crc_step(CRC_INIT, data_byte);
                byte_count_next  = len_t'(1);
              end
            end else if (byte_count <= payload_len) begin
              we               = 1'b1;
              running_crc_next = crc_step(running_crc, data_byte);
              byte_count_next  = byte_count + len_t'(1);
            end else if (byte_count == payload_len + len_t'(1)) begin
              crc_high_byte_next = data_byte;
              byte_count_next    = byte_count + len_t'(1);
            end else begin
              cmd.start          = ({crc_high_byte, data_byte} == running_crc);
              phase_next         = PH_HUNT0;
              byte_count_next    = '0;
              payload_len_next   = '0;
              running_crc_next   = CRC_INIT;
              crc_high_byte_next = '0;
            end
          end
          default: begin
            phase_next = (data_byte == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT0;
      byte_count    <= '0;
      payload_len   <= '0;
      running_crc   <= CRC_INIT;
      crc_high_byte <= '0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      payload_len   <= payload_len_next;
      running_crc   <= running_crc_next;
      crc_high_byte <= crc_high_byte_next;
    end
  end

endmodule

// ===== rtl/plcd_replay.sv =====
// ----------------------------------------------------------------------------
// plcd_replay
// Read back the stored payload of an accepted frame, one byte per transaction.
// ----------------------------------------------------------------------------
module plcd_replay #(
  parameter int MAX_PAYLOAD_BYTES = 64,
  localparam int AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  plcd_pkg::replay_cmd_t cmd,
  output logic [AW-1:0]         raddr,
  input  logic [7:0]            rdata,
  output logic                  busy,
  plcd_out_if.source            out_ch
);
  import plcd_pkg::*;

  logic active;
  logic pend;
  len_t rd_idx;
  len_t pend_idx;
  len_t len;
  logic issue;
  logic out_valid;

  assign raddr        = rd_idx[AW-1:0];
  assign busy         = active | pend;
  assign issue        = active & ~pend & (~out_valid | out_ch.ready);
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        active <= 1'b1;
        rd_idx <= '0;
        len    <= cmd.len;
      end else if (issue) begin
        rd_idx <= rd_idx + len_t'(1);
        if (rd_idx + len_t'(1) == len) begin
          active <= 1'b0;
        end
      end
      if (issue) begin
        pend     <= 1'b1;
        pend_idx <= rd_idx;
      end else begin
        pend <= 1'b0;
      end
      if (pend) begin
        out_valid           <= 1'b1;
        out_ch.payload_byte <= rdata;
        out_ch.byte_index   <= pend_idx[INDEX_W-1:0];
        out_ch.frame_length <= len[FLEN_W-1:0];
        out_ch.last_byte    <= (pend_idx + len_t'(1) == len);
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/preamble_length_crc16_deframer_core.sv =====
// ----------------------------------------------------------------------------
// preamble_length_crc16_deframer_core
// Preamble / length / CRC-16 frame receiver with payload replay.
// ----------------------------------------------------------------------------
//  channel   role    payload
//  in_ch     sink    mode, data_byte
//  out_ch    source  payload_byte, byte_index, frame_length, last_byte
//
//  Received bytes are taken whenever in_ch is ready; the store takes one write per payload byte.
//  On a good CRC the payload is read back from the store into the output register;
//  each read waits until the previous one is captured; in_ch is held off meanwhile.
//  Synchronous reset clears the parser state and the replay control only.
//  out_ch stalls hold the output register; the last byte may wait while in_ch runs.
// ----------------------------------------------------------------------------
module preamble_length_crc16_deframer_core #(
  parameter int MAX_PAYLOAD_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  plcd_in_if.sink    in_ch,
  plcd_out_if.source out_ch
);
  import plcd_pkg::*;

  localparam int AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

  logic          take;
  logic          busy;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  replay_cmd_t   cmd;

  assign in_ch.ready = ~busy;
  assign take        = in_ch.valid & in_ch.ready;

  plcd_parse #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .mode      (in_ch.mode),
    .data_byte (in_ch.data_byte),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .cmd       (cmd)
  );

  plcd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_PAYLOAD_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  plcd_replay #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_replay (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .raddr  (raddr),
    .rdata  (rdata),
    .busy   (busy),
    .out_ch (out_ch)
  );

endmodule
